// ----- design/perfect_power_detector_top_assert.svh -----
// ---------------------------------------------------------------------------
// perfect power detector assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef PERFECT_POWER_DETECTOR_TOP_ASSERT_SVH
`define PERFECT_POWER_DETECTOR_TOP_ASSERT_SVH

// property that holds in the same cycle
`define PPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// property that holds in the next cycle
`define PPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ppd_pkg.sv -----
// ---------------------------------------------------------------------------
// ppd_pkg
// widths, state codes and controller/datapath interface types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppd_pkg;

	localparam int VALUE_W       = 31;
	localparam int MASK_W        = 16;
	localparam int CNT_W         = 5;
	localparam int ROOT_W        = 16;
	localparam int IDX_W         = 4;
	localparam int SQ_CNT_W      = 4;
	localparam int PROD_W        = VALUE_W + ROOT_W;
	localparam int MAX_EXPONENTS = 16;

	localparam logic [CNT_W-1:0]    CNT_RESET     = CNT_W'(1);
	localparam logic [CNT_W-1:0]    CNT_MAX       = CNT_W'(MAX_EXPONENTS);
	localparam logic [SQ_CNT_W-1:0] SQ_LAST       = '1;
	localparam logic [VALUE_W-1:0]  SQ_TOP_BIT    = VALUE_W'(1) << (VALUE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_START,
		ST_SEARCH,
		ST_MUL,
		ST_CMP,
		ST_NEXT,
		ST_DONE
	} ppd_state_t;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic search_init;
		logic mid_load;
		logic mul;
		logic accept_pow;
		logic go_high;
		logic go_low;
		logic set_bit;
		logic next_exp;
		logic out_load;
	} ppd_cmd_t;

	typedef struct packed {
		logic sqrt_last;
		logic count_zero;
		logic range_ok;
		logic prod_gt;
		logic prod_eq;
		logic k_last;
		logic exp_last;
		logic out_free;
	} ppd_sts_t;

endpackage

// ----- design/perfect_power_detector_top.sv -----
// sequence: accept, 16 root steps, then per exponent a binary search on the root, ending
//   on a match or crossed bounds, then the result load; exponent count zero skips the search
// a probe of exponent e takes at most e multiply/compare pairs, at most 16 probes per exponent
// a probe stops early once a product exceeds the value
// one word at a time, next word taken the cycle after the result loads into the output register
// arst_n clears the state machine, output valid and sets exponent_count to 1
// ---------------------------------------------------------------------------
// perfect_power_detector_top
// per-exponent perfect power test of a 31-bit value by binary search on the root
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module perfect_power_detector_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration: exponent_count
	input  logic                       cfg_we,
	input  logic [ppd_pkg::CNT_W-1:0]  cfg_wdata,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // [30:0] value, [31] zero fill
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata    // [15:0] power_mask
);
	import ppd_pkg::*;

	ppd_cmd_t cmd;
	ppd_sts_t sts;

	// controller: walks root, each exponent's search and each power step
	ppd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: root unit, bounds, multiplier, mask and result register
	ppd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value     (s_tdata[VALUE_W-1:0]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_mask  (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- design/ppd_ctrl.sv -----
// ---------------------------------------------------------------------------
// ppd_ctrl
// sequencer for root, binary search and power steps
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perfect_power_detector_top_assert.svh"

module ppd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  ppd_pkg::ppd_sts_t sts,
	output ppd_pkg::ppd_cmd_t cmd
);
	import ppd_pkg::*;

	ppd_state_t state_q;
	ppd_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		s_tready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_last) state_nxt = ST_START;
			end
			ST_START: begin
				if (sts.count_zero) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.search_init = 1'b1;
					state_nxt       = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (sts.range_ok) begin
					cmd.mid_load = 1'b1;
					state_nxt    = ST_MUL;
				end else begin
					state_nxt = ST_NEXT;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_CMP;
			end
			ST_CMP: begin
				if (sts.prod_gt) begin
					cmd.go_high = 1'b1;
					state_nxt   = ST_SEARCH;
				end else if (sts.k_last) begin
					if (sts.prod_eq) begin
						cmd.set_bit = 1'b1;
						state_nxt   = ST_NEXT;
					end else begin
						cmd.go_low = 1'b1;
						state_nxt  = ST_SEARCH;
					end
				end else begin
					cmd.accept_pow = 1'b1;
					state_nxt      = ST_MUL;
				end
			end
			ST_NEXT: begin
				if (sts.exp_last) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.next_exp = 1'b1;
					state_nxt    = ST_START;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	`PPD_ASSERT_NEXT(a_accept_starts_root, s_tvalid && s_tready, state_q == ST_SQRT,
		"accepted word did not start the root")
	`PPD_ASSERT_NOW(a_load_only_idle, cmd.load, state_q == ST_IDLE,
		"load outside idle")

endmodule

// ----- design/ppd_dp.sv -----
// ---------------------------------------------------------------------------
// ppd_dp
// root unit, search bounds, shared multiplier, mask and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perfect_power_detector_top_assert.svh"

module ppd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ppd_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic [ppd_pkg::VALUE_W-1:0]   value,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [ppd_pkg::MASK_W-1:0]    out_mask,
	input  ppd_pkg::ppd_cmd_t             cmd,
	output ppd_pkg::ppd_sts_t             sts
);
	import ppd_pkg::*;

	logic [CNT_W-1:0]    exp_cnt_cfg_q;
	logic [CNT_W-1:0]    count_q;
	logic [VALUE_W-1:0]  value_q;
	logic [VALUE_W-1:0]  rem_q;
	logic [VALUE_W-1:0]  root_q;
	logic [SQ_CNT_W-1:0] sq_cnt_q;
	logic [ROOT_W-1:0]   low_q;
	logic [ROOT_W-1:0]   high_q;
	logic [ROOT_W-1:0]   mid_q;
	logic [VALUE_W-1:0]  pow_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CNT_W-1:0]    k_q;
	logic [IDX_W-1:0]    exp_idx_q;
	logic [MASK_W-1:0]   mask_q;
	logic                out_valid_q;
	logic [MASK_W-1:0]   out_mask_q;

	logic [VALUE_W-1:0]  sq_bit;
	logic [VALUE_W-1:0]  sq_trial;
	logic [ROOT_W:0]     mid_sum;
	logic [CNT_W-1:0]    exp_idx_ext;

	// pair of bits consumed per root step, top pair first
	assign sq_bit      = SQ_TOP_BIT >> {sq_cnt_q, 1'b0};
	assign sq_trial    = root_q + sq_bit;
	assign mid_sum     = {1'b0, low_q} + {1'b0, high_q};
	assign exp_idx_ext = {1'b0, exp_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cnt_cfg_q <= CNT_RESET;
		end else if (cfg_we) begin
			exp_cnt_cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			value_q   <= '0;
			rem_q     <= '0;
			root_q    <= '0;
			sq_cnt_q  <= '0;
			low_q     <= '0;
			high_q    <= '0;
			mid_q     <= '0;
			pow_q     <= '0;
			prod_q    <= '0;
			k_q       <= '0;
			exp_idx_q <= '0;
			mask_q    <= '0;
		end else begin
			if (cmd.load) begin
				count_q   <= (exp_cnt_cfg_q > CNT_MAX) ? CNT_MAX : exp_cnt_cfg_q;
				value_q   <= value;
				rem_q     <= value;
				root_q    <= '0;
				sq_cnt_q  <= '0;
				exp_idx_q <= '0;
				mask_q    <= '0;
				low_q     <= '0;
				high_q    <= '0;
			end
			if (cmd.sqrt_step) begin
				sq_cnt_q <= sq_cnt_q + SQ_CNT_W'(1);
				if (rem_q >= sq_trial) begin
					rem_q  <= rem_q - sq_trial;
					root_q <= (root_q >> 1) + sq_bit;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			if (cmd.search_init) begin
				low_q  <= ROOT_W'(1);
				high_q <= root_q[ROOT_W-1:0];
			end
			if (cmd.mid_load) begin
				mid_q <= mid_sum[ROOT_W:1];
				pow_q <= VALUE_W'(1);
				k_q   <= '0;
			end
			if (cmd.mul) prod_q <= PROD_W'(pow_q) * PROD_W'(mid_q);
			if (cmd.accept_pow) begin
				pow_q <= prod_q[VALUE_W-1:0];
				k_q   <= k_q + CNT_W'(1);
			end
			if (cmd.go_high) high_q <= mid_q - ROOT_W'(1);
			if (cmd.go_low) low_q <= mid_q + ROOT_W'(1);
			if (cmd.set_bit) mask_q[exp_idx_q] <= 1'b1;
			if (cmd.next_exp) exp_idx_q <= exp_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_mask_q <= mask_q;
	end

	assign out_valid = out_valid_q;
	assign out_mask  = out_mask_q;

	always_comb begin
		sts            = '0;
		sts.sqrt_last  = (sq_cnt_q == SQ_LAST);
		sts.count_zero = (count_q == '0);
		sts.range_ok   = (low_q <= high_q);
		sts.prod_gt    = (prod_q > PROD_W'(value_q));
		sts.prod_eq    = (prod_q == PROD_W'(value_q));
		sts.k_last     = (k_q == exp_idx_ext + CNT_W'(1));
		sts.exp_last   = (exp_idx_ext + CNT_W'(1) == count_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

	`PPD_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !out_valid_q || out_ready,
		"pending result overwritten")
	`PPD_ASSERT_NOW(a_mask_within_count, 1'b1, (mask_q >> count_q) == '0,
		"mask bit set beyond exponent count")
	`PPD_ASSERT_NOW(a_bounds_order, 1'b1,
		(ROOT_W + 1)'(low_q) <= (ROOT_W + 1)'(high_q) + (ROOT_W + 1)'(1),
		"search bounds crossed by more than one")

endmodule

// ----- tb/sv/tb_perfect_power_detector_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_perfect_power_detector_top
// checks the per-exponent perfect power mask of every accepted value word
// against a hand-read mask or an independent predictor, over several exponent counts and with
// random gaps on the input stream and random stalls on the result stream
// ---------------------------------------------------------------------------

module tb_perfect_power_detector_top;

	import ppd_pkg::*;

	// largest legal value and a power ceiling above every legal value
	localparam logic [VALUE_W-1:0] VALUE_MAX   = '1;
	localparam longint unsigned    POWER_CAP   = 64'h8000_0000;
	// about 1200 items in all, with a wide margin on the limit
	localparam int unsigned        CYCLE_LIMIT = 60_000_000;
	localparam int                 DRAIN_PAUSE = 8;
	localparam int                 TAIL_PAUSE  = 40;
	localparam int                 IDLE_PCT    = 58;
	localparam int                 BOTH_PCT    = 6;
	localparam int                 NUM_PHASES  = 8;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// one row of the directed table; known rows carry a mask read off by eye
	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [VALUE_W-1:0] value;
		logic               known;
		logic [MASK_W-1:0]  mask;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CNT_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;   // [30:0] value, [31] zero fill
	logic                m_tvalid;
	logic                m_tready;
	logic [15:0]         m_tdata;   // [15:0] power_mask

	// predictor copy of the exponent count register
	logic [CNT_W-1:0]    exp_count;
	// masks still owed by the block, oldest first
	logic [MASK_W-1:0]   pending_masks [$];
	int                  mismatch_count = 0;
	int unsigned         cycle_count = 0;
	int                  idle_pct = 0;
	int                  stall_pct = 0;

	dir_row_t directed_rows [25] = '{
		// reset count: squares only
		'{5'd1,  31'd0,          1'b1, 16'h0000},
		'{5'd1,  31'd1,          1'b1, 16'h0001},
		'{5'd1,  31'd4,          1'b1, 16'h0001},
		'{5'd1,  31'd2,          1'b1, 16'h0000},
		'{5'd1,  VALUE_MAX,      1'b1, 16'h0000},
		'{5'd1,  31'd2147395600, 1'b1, 16'h0001},   // largest square in range
		'{5'd1,  31'd2147395599, 1'b0, 16'h0000},
		// count zero tests nothing
		'{5'd0,  31'd1,          1'b1, 16'h0000},
		'{5'd0,  VALUE_MAX,      1'b1, 16'h0000},
		'{5'd0,  31'd2147395600, 1'b1, 16'h0000},
		// full exponent range
		'{5'd16, 31'd0,          1'b1, 16'h0000},
		'{5'd16, 31'd1,          1'b1, 16'hffff},
		'{5'd16, VALUE_MAX,      1'b1, 16'h0000},   // prime, never a power
		'{5'd16, 31'd65536,      1'b0, 16'h0000},
		'{5'd16, 31'd1073741824, 1'b0, 16'h0000},
		'{5'd16, 31'd129140163,  1'b0, 16'h0000},   // 3^17, top mask bit
		'{5'd16, 31'd131072,     1'b0, 16'h0000},
		'{5'd16, 31'd2146689000, 1'b0, 16'h0000},   // largest cube in range
		// count above the maximum saturates
		'{5'd31, 31'd1,          1'b1, 16'hffff},
		'{5'd31, 31'd262144,     1'b0, 16'h0000},   // 2^18, exponent 18 not tested
		'{5'd31, 31'd1073741824, 1'b0, 16'h0000},
		'{5'd17, 31'd1,          1'b1, 16'hffff},
		'{5'd17, 31'd131072,     1'b0, 16'h0000},
		// square and cube at once
		'{5'd2,  31'd64,         1'b0, 16'h0000},
		'{5'd2,  31'd46656,      1'b0, 16'h0000}
	};

	// random phases: mostly small counts, few items at the slow large counts
	logic [CNT_W-1:0] phase_counts [NUM_PHASES] = '{5'd2, 5'd3, 5'd16, 5'd5,
		5'd1, 5'd31, 5'd0, 5'd9};
	int               phase_items  [NUM_PHASES] = '{350, 250, 50, 200, 150, 40, 50, 80};

	perfect_power_detector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// base^e, clipped to a ceiling above every legal value
	function automatic longint unsigned capped_power(input int unsigned base,
		input int unsigned e);
		longint unsigned p;
		p = 1;
		for (int k = 0; k < e; k++) begin
			p = p * base;
			if (p > POWER_CAP)
				return POWER_CAP;
		end
		return p;
	endfunction

	// mask bit i set when a nonzero v has an exact integer (i+2)-th root
	function automatic logic [MASK_W-1:0] expected_power_mask(input logic [VALUE_W-1:0] v,
		input logic [CNT_W-1:0] cnt);
		logic [MASK_W-1:0] mask;
		int unsigned       n;
		int unsigned       root;
		int unsigned       trial;
		mask = '0;
		n = (cnt > MAX_EXPONENTS) ? MAX_EXPONENTS : cnt;
		for (int i = 0; i < n; i++) begin
			// floor root built one bit at a time from the top
			root = 0;
			for (int b = ROOT_W - 1; b >= 0; b--) begin
				trial = root | (32'd1 << b);
				if (capped_power(trial, i + 2) <= v)
					root = trial;
			end
			// zero is never a power
			if (v != 0 && capped_power(root, i + 2) == v)
				mask[i] = 1'b1;
		end
		return mask;
	endfunction

	// largest base whose e-th power stays in range
	function automatic int unsigned max_base(input int unsigned e);
		case (e)
			2:       return 46340;
			3:       return 1290;
			4:       return 215;
			5:       return 73;
			6:       return 35;
			7:       return 21;
			8:       return 14;
			9:       return 10;
			10:      return 8;
			11:      return 7;
			12, 13:  return 5;
			14, 15:  return 4;
			16, 17, 18, 19: return 3;
			default: return 2;
		endcase
	endfunction

	// mostly exact powers and their neighbors, then small, random and edge values
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned     sel;
		int unsigned     e;
		longint unsigned p;
		sel = $urandom_range(99);
		if (sel < 60) begin
			e = ($urandom_range(1) == 1) ? $urandom_range(2, 5) : $urandom_range(2, 30);
			p = capped_power($urandom_range(1, max_base(e)), e);
			if (sel >= 45)
				p = ($urandom_range(1) == 1) ? p + 1 : p - 1;
			return VALUE_W'(p);
		end
		if (sel < 75)
			return VALUE_W'($urandom_range(300));
		if (sel < 95)
			return VALUE_W'($urandom());
		case ($urandom_range(3))
			0:       return '0;
			1:       return VALUE_MAX;
			2:       return VALUE_W'(1) << (VALUE_W - 1);
			default: return VALUE_MAX - 1;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic set_idle_mode(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				idle_pct  = IDLE_PCT;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				idle_pct  = 0;
				stall_pct = IDLE_PCT;
			end
			IDLE_BOTH: begin
				idle_pct  = BOTH_PCT;
				stall_pct = BOTH_PCT;
			end
			default: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// hold the input side until every owed mask has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_masks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// register writes only happen with the block idle
	task automatic write_exponent_count(input logic [CNT_W-1:0] c);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
		exp_count = c;
	endtask

	// offer one value word; valid stays high afterwards unless a gap follows
	task automatic send_value(input logic [VALUE_W-1:0] v, input logic known,
		input logic [MASK_W-1:0] mask);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, v};
		do @(posedge clk); while (!s_tready);
		pending_masks.push_back(known ? mask : expected_power_mask(v, exp_count));
	endtask

	// result side: compare each accepted word, then pick next ready
	always @(posedge clk) begin : result_check
		logic [MASK_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_masks.size() == 0) begin
				report_mismatch($sformatf("unexpected result word %h", m_tdata));
			end else begin
				want = pending_masks.pop_front();
				if (m_tdata !== want)
					report_mismatch($sformatf("power_mask %h, expected %h", m_tdata, want));
			end
		end
		m_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		exp_count = CNT_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling; count changes drain first
		foreach (directed_rows[r]) begin
			if (directed_rows[r].count != exp_count)
				write_exponent_count(directed_rows[r].count);
			send_value(directed_rows[r].value, directed_rows[r].known, directed_rows[r].mask);
		end

		// random phases, each with its own count and idling pattern
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_exponent_count(phase_counts[p]);
			set_idle_mode(idle_mode_t'(p % 4));
			for (int n = 0; n < phase_items[p]; n++) begin
				// now and then let the block run dry before the next word
				if ($urandom_range(39) == 0)
					wait_drained();
				send_value(pick_value(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL_PAUSE) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/ppd_pkg.sv
design/ppd_ctrl.sv
design/ppd_dp.sv
design/perfect_power_detector_top.sv
tb/sv/tb_perfect_power_detector_top.sv
